### rtl/window_denoise_filter_3x3_assert.svh
// assertion macros for the 3x3 window denoise filter
`ifndef WINDOW_DENOISE_FILTER_3X3_ASSERT_SVH
`define WINDOW_DENOISE_FILTER_3X3_ASSERT_SVH

// condition must hold at every edge outside reset
`define WDF_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define WDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/wdf_pkg.sv
// shared types and constants of the 3x3 window denoise filter
package wdf_pkg;

    localparam int PIX_BITS      = 8;
    localparam int NEAREST_COUNT = 5;
    localparam int MAX_HEIGHT    = 1024;
    localparam int LINE_BITS     = 10;
    localparam int HEIGHT_BITS   = 11;
    localparam int CFG_BITS      = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int SUM_BITS      = 11;
    localparam int MED_RANK_BITS = 4;
    localparam int KNN_RANK_BITS = 3;
    localparam int KNN_SHIFT     = 20;
    localparam int KNN_MULT      = ((1 << KNN_SHIFT) + NEAREST_COUNT - 1) / NEAREST_COUNT;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = 2;
    localparam int QCNT_BITS     = 3;

    localparam logic [CFG_BITS-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_BITS-1:0] RESET_HEIGHT = 11'd480;

    typedef logic [PIX_BITS-1:0] t_pixel;

    typedef enum logic [1:0] {
        MODE_MEAN   = 2'd0,
        MODE_MEDIAN = 2'd1,
        MODE_KNN    = 2'd2,
        MODE_PASS   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FILTER_MODE  = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req;

    typedef struct packed {
        t_pixel [8:0] win;
        logic         border;
        logic         first;
        logic         last;
    } t_win_item;

endpackage

### rtl/wdf_in_if.sv
// input channel: pixel and drain transactions
interface wdf_in_if;
    logic             valid;
    logic             ready;
    logic             req_type;
    wdf_pkg::t_pixel  pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

### rtl/wdf_out_if.sv
// output channel: filtered pixels with frame markers
interface wdf_out_if;
    logic             valid;
    logic             ready;
    wdf_pkg::t_pixel  pixel_out;
    logic             frame_first;
    logic             frame_last;

    modport source (output valid, output pixel_out, output frame_first, output frame_last,
                    input ready);
    modport sink (input valid, input pixel_out, input frame_first, input frame_last,
                  output ready);
endinterface

### rtl/wdf_front.sv
// front end: raster counters, line stores and window shift
module wdf_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [wdf_pkg::CFG_BITS-1:0]          i_frame_width,
    input  logic [wdf_pkg::CFG_BITS-1:0]          i_frame_height,
    input  logic [wdf_pkg::QCNT_BITS-1:0]         i_q_count,
    wdf_in_if.sink                                i_in,
    output logic                                  o_push,
    output wdf_pkg::t_win_item                    o_item
);
    import wdf_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW = $clog2(MAX_WIDTH + 2);

    logic [PW-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;

    logic [AW-1:0]        r_in_col, n_in_col;
    logic [LINE_BITS-1:0] r_in_line, n_in_line;
    logic [AW-1:0]        r_out_col, n_out_col;
    logic [LINE_BITS-1:0] r_out_line, n_out_line;
    logic [PW-1:0]        r_pend, n_pend;

    // second stage: store data arrives, window shifts
    logic                 r_b_valid;
    logic                 r_b_emit;
    logic [AW-1:0]        r_b_addr;
    t_pixel               r_b_px;
    logic                 r_b_fwd;
    logic                 r_b_border, r_b_first, r_b_last;
    t_pixel               r_up_rd, r_mid_rd;
    t_pixel               r_last_mid, r_last_px;
    t_pixel [8:0]         r_win, n_win;
    t_pixel               r_upper_mem [MAX_WIDTH];
    t_pixel               r_middle_mem [MAX_WIDTH];

    logic                 accept;
    logic                 at_start;
    logic [PW-1:0]        thr;
    logic                 b_load, emit;
    logic [AW-1:0]        addr;
    t_pixel               px;
    logic                 border, first, last;
    logic [AW-1:0]        oc;
    logic [LINE_BITS-1:0] ol;
    logic [PW-1:0]        pend;
    logic [PW-1:0]        col_inc;
    logic [PW-1:0]        ocol_inc;
    logic [HEIGHT_BITS-1:0] line_inc;
    logic [HEIGHT_BITS-1:0] oline_inc;
    t_pixel               up_eff, mid_eff;

    always_comb begin
        if (i_frame_width < 11'd3) begin
            w_eff = PW'(3);
        end else if (32'(i_frame_width) > MAX_WIDTH) begin
            w_eff = PW'(MAX_WIDTH);
        end else begin
            w_eff = PW'(i_frame_width);
        end
        if (i_frame_height < 11'd3) begin
            h_eff = HEIGHT_BITS'(3);
        end else if (32'(i_frame_height) > MAX_HEIGHT) begin
            h_eff = HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = i_frame_height;
        end
    end

    assign i_in.ready = (QCNT_BITS'(i_q_count) + QCNT_BITS'(r_b_valid && r_b_emit))
                        < QCNT_BITS'(QUEUE_DEPTH);
    assign accept   = i_in.valid && i_in.ready;
    assign at_start = (r_in_col == '0) && (r_in_line == '0);
    assign thr      = w_eff + PW'(1);

    always_comb begin
        n_in_col   = r_in_col;
        n_in_line  = r_in_line;
        n_out_col  = r_out_col;
        n_out_line = r_out_line;
        n_pend     = r_pend;
        b_load     = 1'b0;
        emit       = 1'b0;
        addr       = r_in_col;
        px         = '0;
        oc         = r_out_col;
        ol         = r_out_line;
        pend       = r_pend;
        col_inc    = PW'(r_in_col) + PW'(1);
        line_inc   = HEIGHT_BITS'(r_in_line) + HEIGHT_BITS'(1);
        ocol_inc   = '0;
        oline_inc  = '0;
        border     = 1'b0;
        first      = 1'b0;
        last       = 1'b0;
        if (accept) begin
            if (i_in.req_type == REQ_DRAIN) begin
                if (at_start && (r_pend != '0)) begin
                    ocol_inc = PW'(r_out_col) + PW'(1);
                    addr     = (ocol_inc >= w_eff) ? '0 : ocol_inc[AW-1:0];
                    emit     = 1'b1;
                    b_load   = 1'b1;
                    n_pend   = r_pend - PW'(1);
                end
            end else begin
                // interrupted drain drops the unflushed tail
                if (at_start && (r_pend < thr)) begin
                    pend = '0;
                    oc   = '0;
                    ol   = '0;
                end
                addr   = r_in_col;
                px     = i_in.pixel_in;
                b_load = 1'b1;
                if (col_inc >= w_eff) begin
                    n_in_col = '0;
                    n_in_line = (line_inc >= h_eff) ? '0 : line_inc[LINE_BITS-1:0];
                end else begin
                    n_in_col = col_inc[AW-1:0];
                end
                if (pend >= thr) begin
                    emit   = 1'b1;
                    n_pend = pend;
                end else begin
                    n_pend = pend + PW'(1);
                end
                n_out_col  = oc;
                n_out_line = ol;
            end
            if (emit) begin
                border = (ol == '0) || (HEIGHT_BITS'(ol) >= h_eff - HEIGHT_BITS'(1)) ||
                         (oc == '0) || (PW'(oc) >= w_eff - PW'(1));
                first  = (ol == '0) && (oc == '0);
                last   = (HEIGHT_BITS'(ol) >= h_eff - HEIGHT_BITS'(1)) &&
                         (PW'(oc) >= w_eff - PW'(1));
                ocol_inc  = PW'(oc) + PW'(1);
                oline_inc = HEIGHT_BITS'(ol) + HEIGHT_BITS'(1);
                if (ocol_inc >= w_eff) begin
                    n_out_col  = '0;
                    n_out_line = (oline_inc >= h_eff) ? '0 : oline_inc[LINE_BITS-1:0];
                end else begin
                    n_out_col  = ocol_inc[AW-1:0];
                    n_out_line = ol;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_line  <= '0;
            r_out_col  <= '0;
            r_out_line <= '0;
            r_pend     <= '0;
            r_b_valid  <= 1'b0;
            r_b_emit   <= 1'b0;
            r_b_fwd    <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_line  <= n_in_line;
            r_out_col  <= n_out_col;
            r_out_line <= n_out_line;
            r_pend     <= n_pend;
            r_b_valid  <= b_load;
            r_b_emit   <= emit;
            // previous transaction writes this column in the same cycle
            r_b_fwd    <= b_load && r_b_valid && (addr == r_b_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_addr   <= addr;
            r_b_px     <= px;
            r_b_border <= border;
            r_b_first  <= first;
            r_b_last   <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_up_rd  <= r_upper_mem[addr];
            r_mid_rd <= r_middle_mem[addr];
        end
        if (r_b_valid) begin
            r_upper_mem[r_b_addr]  <= mid_eff;
            r_middle_mem[r_b_addr] <= r_b_px;
        end
    end

    assign up_eff  = r_b_fwd ? r_last_mid : r_up_rd;
    assign mid_eff = r_b_fwd ? r_last_px  : r_mid_rd;

    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]   = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = up_eff;
        n_win[5] = mid_eff;
        n_win[8] = r_b_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_b_valid) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_last_mid <= mid_eff;
            r_last_px  <= r_b_px;
        end
    end

    assign o_push        = r_b_valid && r_b_emit;
    assign o_item.win    = n_win;
    assign o_item.border = r_b_border;
    assign o_item.first  = r_b_first;
    assign o_item.last   = r_b_last;

endmodule

### rtl/wdf_queue.sv
// short queue of windows between front end and filter
module wdf_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  wdf_pkg::t_win_item            i_item,
    input  logic                          i_pop,
    output wdf_pkg::t_win_item            o_head,
    output logic                          o_not_empty,
    output logic [wdf_pkg::QCNT_BITS-1:0] o_count
);
    import wdf_pkg::*;

    t_win_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0]  r_count;
    logic                  do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_BITS'(1);
                2'b01:   r_count <= r_count - QCNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;

endmodule

### rtl/wdf_back.sv
// back end: ranking, selection, division and output register
module wdf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wdf_pkg::t_mode       i_mode,
    input  wdf_pkg::t_win_item   i_head,
    input  logic                 i_not_empty,
    output logic                 o_pop,
    wdf_out_if.source            o_out
);
    import wdf_pkg::*;

    logic adv;

    // stage 1: ranks
    logic                      r_s1_valid;
    t_win_item                 r_s1_item;
    logic [MED_RANK_BITS-1:0]  r_s1_med_rank [9];
    logic [KNN_RANK_BITS-1:0]  r_s1_knn_rank [8];
    logic [SUM_BITS-1:0]       r_s1_nsum;
    logic [MED_RANK_BITS-1:0]  med_rank [9];
    logic [KNN_RANK_BITS-1:0]  knn_rank [8];
    logic [SUM_BITS-1:0]       nsum;
    t_pixel                    nb [8];
    logic [2*PIX_BITS-1:0]     key [8];
    t_pixel                    ctr;

    // stage 2: selection
    logic                      r_s2_valid;
    logic                      r_s2_border, r_s2_first, r_s2_last;
    t_pixel                    r_s2_center, r_s2_mean, r_s2_median;
    logic [SUM_BITS-1:0]       r_s2_knn_sum;
    t_pixel                    med_sel;
    logic [SUM_BITS-1:0]       knn_sum;

    // output stage
    logic                      r_o_valid;
    t_pixel                    r_o_pixel;
    logic                      r_o_first, r_o_last;
    logic [31:0]               knn_prod;
    t_pixel                    knn_val;
    t_pixel                    res;

    assign adv   = !r_o_valid || o_out.ready;
    assign o_pop = adv && i_not_empty;

    always_comb begin
        logic [MED_RANK_BITS-1:0] mcnt;
        logic [KNN_RANK_BITS-1:0] kcnt;
        t_pixel gap;
        ctr  = i_head.win[4];
        nsum = '0;
        for (int i = 0; i < 9; i++) begin
            mcnt = '0;
            for (int j = 0; j < 9; j++) begin
                if (j != i) begin
                    if ((i_head.win[j] < i_head.win[i]) ||
                        ((i_head.win[j] == i_head.win[i]) && (j < i))) begin
                        mcnt = mcnt + MED_RANK_BITS'(1);
                    end
                end
            end
            med_rank[i] = mcnt;
        end
        for (int k = 0; k < 8; k++) begin
            nb[k]  = (k < 4) ? i_head.win[k] : i_head.win[k+1];
            gap    = (nb[k] > ctr) ? (nb[k] - ctr) : (ctr - nb[k]);
            key[k] = {gap, nb[k]};
            nsum   = nsum + SUM_BITS'(nb[k]);
        end
        for (int k = 0; k < 8; k++) begin
            kcnt = '0;
            for (int j = 0; j < 8; j++) begin
                if (j != k) begin
                    if ((key[j] < key[k]) || ((key[j] == key[k]) && (j < k))) begin
                        kcnt = kcnt + KNN_RANK_BITS'(1);
                    end
                end
            end
            knn_rank[k] = kcnt;
        end
    end

    always_comb begin
        med_sel = '0;
        knn_sum = '0;
        for (int i = 0; i < 9; i++) begin
            if (r_s1_med_rank[i] == MED_RANK_BITS'(4)) begin
                med_sel = med_sel | r_s1_item.win[i];
            end
        end
        for (int k = 0; k < 8; k++) begin
            if (32'(r_s1_knn_rank[k]) < NEAREST_COUNT) begin
                knn_sum = knn_sum + SUM_BITS'((k < 4) ? r_s1_item.win[k] : r_s1_item.win[k+1]);
            end
        end
    end

    assign knn_prod = 32'(r_s2_knn_sum) * 32'(KNN_MULT);
    assign knn_val  = knn_prod[KNN_SHIFT +: PIX_BITS];

    always_comb begin
        if (r_s2_border) begin
            res = r_s2_center;
        end else begin
            unique case (i_mode)
                MODE_MEAN:   res = r_s2_mean;
                MODE_MEDIAN: res = r_s2_median;
                MODE_KNN:    res = knn_val;
                MODE_PASS:   res = r_s2_center;
                default:     res = r_s2_center;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_not_empty;
            r_s2_valid <= r_s1_valid;
            r_o_valid  <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_item     <= i_head;
            r_s1_med_rank <= med_rank;
            r_s1_knn_rank <= knn_rank;
            r_s1_nsum     <= nsum;
            r_s2_border   <= r_s1_item.border;
            r_s2_first    <= r_s1_item.first;
            r_s2_last     <= r_s1_item.last;
            r_s2_center   <= r_s1_item.win[4];
            r_s2_mean     <= r_s1_nsum[SUM_BITS-1:3];
            r_s2_median   <= med_sel;
            r_s2_knn_sum  <= knn_sum;
            r_o_pixel     <= res;
            r_o_first     <= r_s2_first;
            r_o_last      <= r_s2_last;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.pixel_out   = r_o_pixel;
    assign o_out.frame_first = r_o_first;
    assign o_out.frame_last  = r_o_last;

endmodule

### rtl/window_denoise_filter_3x3.sv
// top level of the 3x3 window denoise filter
//
// i_in carries raster pixel transactions (req_type 0) and drain transactions
// (req_type 1); o_out gives filtered pixels in raster order with frame_first
// and frame_last markers. Border pixels pass unchanged; interior pixels take
// the neighbour mean, the median of nine, the mean of the nearest values or
// the centre unchanged, by filter_mode. Output runs one line plus one pixel
// behind the input; drains after a frame push out the pixels still held back.
// Throughput is one transaction per cycle while the window queue has room. A
// transaction passes through the front end (line store read, then window
// shift), the window queue and the filter pipeline (rank, select, divide).
// When o_out.ready is low the filter pipeline holds; the four-entry window
// queue absorbs what is in flight and i_in.ready drops once it is full.
// Reset clears counters, window and pipeline and loads mode 1, 640 x 480;
// line store contents are not cleared.
// Configuration writes take effect at once; the user must make them only while idle, as the block does not enforce it.
module window_denoise_filter_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wdf_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [wdf_pkg::CFG_BITS-1:0]        i_cfg_data,
    wdf_in_if.sink                              i_in,
    wdf_out_if.source                           o_out
);
    import wdf_pkg::*;

    t_mode                 r_filter_mode;
    logic [CFG_BITS-1:0]   r_frame_width;
    logic [CFG_BITS-1:0]   r_frame_height;

    logic                  q_push;
    t_win_item             q_item;
    t_win_item             q_head;
    logic                  q_not_empty;
    logic                  q_pop;
    logic [QCNT_BITS-1:0]  q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode  <= MODE_MEDIAN;
            r_frame_width  <= RESET_WIDTH;
            r_frame_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_MODE:  r_filter_mode  <= t_mode'(i_cfg_data[1:0]);
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wdf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_q_count      (q_count),
        .i_in           (i_in),
        .o_push         (q_push),
        .o_item         (q_item)
    );

    wdf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_item      (q_item),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_not_empty (q_not_empty),
        .o_count     (q_count)
    );

    wdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_filter_mode),
        .i_head      (q_head),
        .i_not_empty (q_not_empty),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

`include "window_denoise_filter_3x3_assert.svh"

    `WDF_ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, 32'(q_count) <= QUEUE_DEPTH, "queue overflow")
    `WDF_ASSERT_IMPLY(a_full_stall, i_clk, i_rst_n, 32'(q_count) == QUEUE_DEPTH, !i_in.ready, "input taken with full queue")
    `WDF_ASSERT_NEXT(a_q_grow, i_clk, i_rst_n, q_push && !q_pop, q_count == $past(q_count) + QCNT_BITS'(1), "queue count lost a push")

endmodule
